/* rtl/core/keyed_record_table_assert.svh */
// Assertion macros for the keyed record table checker.
// Depends on nothing; expects clk_i and rst_ni in the scope of each use.
`ifndef KEYED_RECORD_TABLE_ASSERT_SVH
`define KEYED_RECORD_TABLE_ASSERT_SVH

// Concurrent check on the rising clock, disabled while reset is asserted.
`define KRT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent check on the rising clock that also holds during reset.
`define KRT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/core/krt_pkg.sv */
// Shared types, constants and field layout of the keyed record table.
// No dependencies; imported by the table and its checker.
package krt_pkg;

  localparam int ENTRIES  = 128;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int KEY_W    = 37;
  localparam int NAME_W   = 64;
  localparam int POS_W    = 8;
  localparam int TOTAL_W  = 8;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;

  localparam int REC_W         = 2 * KEY_W + 2 * NAME_W;
  localparam int IN_DATA_W     = ((REC_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W   = POS_W + REC_W + TOTAL_W;
  localparam int OUT_DATA_W    = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_REC_LSB   = POS_W;
  localparam int OUT_TOTAL_LSB = POS_W + REC_W;

  // id sits in the lowest bits
  typedef struct packed {
    logic [NAME_W-1:0] last_name;
    logic [NAME_W-1:0] first_name;
    logic [KEY_W-1:0]  phone;
    logic [KEY_W-1:0]  id;
  } rec_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT     = 2'd0,
    FN_DELETE     = 2'd1,
    FN_FIND_ID    = 2'd2,
    FN_FIND_PHONE = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_e;

endpackage

/* rtl/core/keyed_record_table.sv */
// Keyed record table: insert, delete by id, find by id, find by phone.
// Insert goes straight to the result; find and delete sweep all N records held, and a delete
// hit at slot h then moves each record above slot h one slot down to close the gap.
// One transaction at a time: the next is taken in the same cycle the result is presented; the
// single read port of the record memory feeds the one shared comparator.
// Reset (async, active low) empties the table and drops any pending result; memory not cleared.
module keyed_record_table (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // id[36:0], phone[73:37], first_name[137:74], last_name[201:138], zero pad
  input  logic [krt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // func[1:0]
  input  logic [krt_pkg::FUNC_W-1:0]       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // position[7:0], rec_id[44:8], rec_phone[81:45], rec_first_name[145:82],
  // rec_last_name[209:146], entry_total[217:210], zero pad
  output logic [krt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // status[1:0]
  output logic [krt_pkg::STATUS_W-1:0]     m_axis_tuser
);
  import krt_pkg::*;

  // Control state
  state_e           state_q, state_d;
  func_e            func_q, func_d;
  logic [CNT_W-1:0] count_q, count_d;       // records held
  logic [CNT_W-1:0] addr_q, addr_d;         // next slot to read
  logic             pend_q, pend_d;         // a read is in flight
  logic [CNT_W-1:0] pend_addr_q, pend_addr_d;
  logic [CNT_W-1:0] below_q, below_d;       // keys smaller than the search key
  logic             hit_q, hit_d;
  logic [CNT_W-1:0] hit_idx_q, hit_idx_d;
  logic             m_valid_q, m_valid_d;

  // Payload state
  logic [KEY_W-1:0]   key_q, key_d;
  rec_t               op_rec_q, op_rec_d;
  rec_t               hit_rec_q, hit_rec_d;
  status_e            out_status_q, out_status_d;
  logic [POS_W-1:0]   out_pos_q, out_pos_d;
  rec_t               out_rec_q, out_rec_d;
  logic [TOTAL_W-1:0] out_total_q, out_total_d;

  // Record memory: one write port, one registered read port
  rec_t             rec_mem [ENTRIES];
  rec_t             rd_data_q;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  rec_t             mem_wdata;

  rec_t             in_rec;
  logic             issue;
  logic             out_free;
  logic [KEY_W-1:0] stored_key;
  logic             key_lt;
  logic             key_eq;

  assign in_rec   = rec_t'(s_axis_tdata[REC_W-1:0]);
  // More slots left to read in the current sweep
  assign issue    = (addr_q < count_q);
  // Output register can take a new result this cycle
  assign out_free = !m_valid_q || m_axis_tready;

  // Shared compare unit: stored key against the search key
  assign stored_key = (func_q == FN_FIND_PHONE) ? rd_data_q.phone : rd_data_q.id;
  assign key_lt     = (stored_key < key_q);
  assign key_eq     = (stored_key == key_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rec_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= rec_mem[rd_addr];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = (func_e'(s_axis_tuser) == FN_INSERT) ? S_RESP : S_SCAN;
        end
      end
      S_SCAN: begin
        // Sweep ends once the last read has been compared
        if (!pend_q && !issue) begin
          state_d = (func_q == FN_DELETE && hit_q) ? S_SHIFT : S_RESP;
        end
      end
      S_SHIFT: begin
        if (!pend_q && !issue) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    func_d       = func_q;
    key_d        = key_q;
    op_rec_d     = op_rec_q;
    count_d      = count_q;
    addr_d       = addr_q;
    pend_d       = 1'b0;
    pend_addr_d  = pend_addr_q;
    below_d      = below_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    hit_rec_d    = hit_rec_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_pos_d    = out_pos_q;
    out_rec_d    = out_rec_q;
    out_total_d  = out_total_q;
    rd_addr      = addr_q[IDX_W-1:0];
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = rd_data_q;
    s_axis_tready = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          func_d   = func_e'(s_axis_tuser);
          key_d    = (func_e'(s_axis_tuser) == FN_FIND_PHONE) ? in_rec.phone : in_rec.id;
          op_rec_d = in_rec;
          addr_d   = '0;
          below_d  = '0;
          hit_d    = 1'b0;
        end
      end
      S_SCAN: begin
        if (issue) begin
          pend_d      = 1'b1;
          pend_addr_d = addr_q;
          addr_d      = addr_q + CNT_W'(1);
        end
        if (pend_q) begin
          // Count smaller keys, latch the earliest equal one
          if (key_lt) begin
            below_d = below_q + CNT_W'(1);
          end else if (key_eq && !hit_q) begin
            hit_d     = 1'b1;
            hit_idx_d = pend_addr_q;
            hit_rec_d = rd_data_q;
          end
        end
        // Start compaction just past the removed slot
        if (!pend_q && !issue && func_q == FN_DELETE && hit_q) begin
          addr_d = hit_idx_q + CNT_W'(1);
        end
      end
      S_SHIFT: begin
        if (issue) begin
          pend_d      = 1'b1;
          pend_addr_d = addr_q;
          addr_d      = addr_q + CNT_W'(1);
        end
        // Move each record one slot down
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = IDX_W'(pend_addr_q - CNT_W'(1));
          mem_wdata = rd_data_q;
        end
      end
      S_RESP: begin
        if (out_free) begin
          m_valid_d    = 1'b1;
          out_status_d = ST_OK;
          out_pos_d    = '0;
          out_rec_d    = '0;
          case (func_q)
            FN_INSERT: begin
              if (count_q >= CNT_W'(ENTRIES)) begin
                out_status_d = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_q[IDX_W-1:0];
                mem_wdata = op_rec_q;
                out_rec_d = op_rec_q;
                count_d   = count_q + CNT_W'(1);
              end
            end
            FN_DELETE: begin
              if (hit_q) begin
                out_rec_d = hit_rec_q;
                count_d   = count_q - CNT_W'(1);
              end else begin
                out_status_d = ST_NOT_FOUND;
              end
            end
            default: begin
              if (hit_q) begin
                out_rec_d = hit_rec_q;
                out_pos_d = POS_W'(below_q);
              end else begin
                out_status_d = ST_NOT_FOUND;
              end
            end
          endcase
          out_total_d = TOTAL_W'(count_d);
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      func_q      <= FN_INSERT;
      count_q     <= '0;
      addr_q      <= '0;
      pend_q      <= 1'b0;
      pend_addr_q <= '0;
      below_q     <= '0;
      hit_q       <= 1'b0;
      hit_idx_q   <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      func_q      <= func_d;
      count_q     <= count_d;
      addr_q      <= addr_d;
      pend_q      <= pend_d;
      pend_addr_q <= pend_addr_d;
      below_q     <= below_d;
      hit_q       <= hit_d;
      hit_idx_q   <= hit_idx_d;
      m_valid_q   <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    op_rec_q     <= op_rec_d;
    hit_rec_q    <= hit_rec_d;
    out_status_q <= out_status_d;
    out_pos_q    <= out_pos_d;
    out_rec_q    <= out_rec_d;
    out_total_q  <= out_total_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = OUT_DATA_W'({out_total_q, out_rec_q, out_pos_q});

endmodule

/* rtl/core/krt_checker.sv */
// Port-level checker for the keyed record table, bound to the top level.
// Depends on krt_pkg and keyed_record_table_assert.svh.
`include "keyed_record_table_assert.svh"

module krt_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [krt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [krt_pkg::STATUS_W-1:0]   m_axis_tuser
);
  import krt_pkg::*;

  logic                             in_take;
  logic                             out_stall;
  logic                             out_full;
  logic                             out_miss;
  logic                             total_max;
  logic                             rec_clear;
  logic [OUT_DATA_W+STATUS_W-1:0]   out_word;

  assign in_take   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_full  = m_axis_tvalid && (m_axis_tuser == ST_FULL);
  assign out_miss  = m_axis_tvalid && (m_axis_tuser == ST_NOT_FOUND);
  assign total_max = (m_axis_tdata[OUT_TOTAL_LSB +: TOTAL_W] == TOTAL_W'(ENTRIES));
  // Position and record fields all zero
  assign rec_clear = (m_axis_tdata[OUT_TOTAL_LSB-1:0] == '0);
  assign out_word  = {m_axis_tuser, m_axis_tdata};

  `KRT_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(out_word), "result moved")
  `KRT_ASSERT(a_busy_after_accept, in_take |=> !s_axis_tready, "accepted back to back")
  `KRT_ASSERT(a_full_result, out_full |-> total_max && rec_clear, "bad table full result")
  `KRT_ASSERT(a_miss_result, out_miss |-> rec_clear, "miss carries record data")
  `KRT_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !m_axis_tvalid, "result valid out of reset")

endmodule

bind keyed_record_table krt_checker u_krt_checker (.*);
